FILE: hdl/lcsl_pkg.sv
// ----------------------------------------------------------------------------
// lcsl_pkg: shared types and constants
// Field widths, op codes and the engine status word for the longest common
// substring length block.
// ----------------------------------------------------------------------------
package lcsl_pkg;

  localparam int MaxLenDefault = 1024;

  localparam int OpW    = 2;
  localparam int SymW   = 8;
  localparam int MatchW = 11;

  localparam logic [OpW-1:0] OpFirst  = 2'd0;
  localparam logic [OpW-1:0] OpSecond = 2'd1;
  localparam logic [OpW-1:0] OpFinish = 2'd2;

  // largest length the result field can carry
  localparam logic [MatchW-1:0] LenFieldMax = 11'd2047;

  typedef struct packed {
    logic              done;
    logic [MatchW-1:0] length;
  } eng_status_t;

endpackage

FILE: hdl/lcsl_req_if.sv
// ----------------------------------------------------------------------------
// lcsl_req_if: input channel
// One word carries an op code and a symbol byte.
// ----------------------------------------------------------------------------
interface lcsl_req_if;
  logic                      valid;
  logic                      ready;
  logic [lcsl_pkg::OpW-1:0]  op;
  logic [lcsl_pkg::SymW-1:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink   (input valid, input op, input symbol, output ready);
endinterface

FILE: hdl/lcsl_rsp_if.sv
// ----------------------------------------------------------------------------
// lcsl_rsp_if: result channel
// One word carries the match length and the overflow flag.
// ----------------------------------------------------------------------------
interface lcsl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lcsl_pkg::MatchW-1:0] match_length;
  logic                        overflow;

  modport source (output valid, output match_length, output overflow, input ready);
  modport sink   (input valid, input match_length, input overflow, output ready);
endinterface

FILE: hdl/longest_common_substring_length.sv
// ----------------------------------------------------------------------------
// longest_common_substring_length: top level
// Flow: an append word is written to its string's store; a finish word starts
//   the diagonal scan, which skips the walk with an empty string.
// Throughput: one append per cycle; during a finish the block is not ready
//   until the scan ends and the result register is free, set by the
//   one-cell-per-cycle diagonal scanner.
// Reset: synchronous, active high; clears counts, drop flags and out_valid.
//   Store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module longest_common_substring_length #(
  parameter int MAX_LEN = lcsl_pkg::MaxLenDefault
) (
  input  logic       clk,
  input  logic       rst,
  lcsl_req_if.sink   req,
  lcsl_rsp_if.source rsp
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_LEN);
  localparam logic [CW-1:0] One    = CW'(1);

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_HOLD} state_t;

  state_t                        state;
  logic [CW-1:0]                 cnt_a, cnt_b;    // symbols held per string
  logic                          dropped;         // a symbol was lost since finish
  logic                          pend_ovf;        // flag for the result in flight
  logic                          out_valid;
  logic [lcsl_pkg::MatchW-1:0]   out_len;
  logic                          out_ovf;

  logic                          accept;
  logic                          wr_a, wr_b;
  logic                          start;
  logic                          slot_free;
  logic                          load_out;
  logic [AW-1:0]                 addr_a, addr_b;
  logic [lcsl_pkg::SymW-1:0]     data_a, data_b;
  lcsl_pkg::eng_status_t         status;

  // New words only while no scan is running.
  assign req.ready = (state == T_IDLE);
  assign accept    = req.valid && req.ready;

  assign wr_a  = accept && (req.op == lcsl_pkg::OpFirst)  && (cnt_a < MaxCnt);
  assign wr_b  = accept && (req.op == lcsl_pkg::OpSecond) && (cnt_b < MaxCnt);
  assign start = accept && (req.op == lcsl_pkg::OpFinish);

  // Output register frees up this cycle if empty or being taken.
  assign slot_free = !out_valid || rsp.ready;

  // Scan result moves into the output register once there is room.
  assign load_out = slot_free &&
                    (((state == T_RUN) && status.done) || (state == T_HOLD));

  assign rsp.valid        = out_valid;
  assign rsp.match_length = out_len;
  assign rsp.overflow     = out_ovf;

  lcsl_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a[AW-1:0]),
    .wr_data (req.symbol),
    .rd_addr (addr_a),
    .rd_data (data_a)
  );

  lcsl_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b[AW-1:0]),
    .wr_data (req.symbol),
    .rd_addr (addr_b),
    .rd_data (data_b)
  );

  // Scanner latches the counts at start, so they can be cleared right away.
  lcsl_engine #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW)) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .len_a  (cnt_a),
    .len_b  (cnt_b),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (data_a),
    .data_b (data_b),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      dropped   <= 1'b0;
      pend_ovf  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        out_len   <= status.length;
        out_ovf   <= pend_ovf;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            case (req.op)
              lcsl_pkg::OpFirst: begin
                if (cnt_a < MaxCnt) cnt_a <= cnt_a + One;
                else                dropped <= 1'b1;
              end
              lcsl_pkg::OpSecond: begin
                if (cnt_b < MaxCnt) cnt_b <= cnt_b + One;
                else                dropped <= 1'b1;
              end
              lcsl_pkg::OpFinish: begin
                pend_ovf <= dropped;
                dropped  <= 1'b0;
                cnt_a    <= '0;
                cnt_b    <= '0;
                state    <= T_RUN;
              end
              default: ;  // unused op: word dropped, nothing changes
            endcase
          end
        end
        T_RUN: begin
          if (status.done) begin
            state <= slot_free ? T_IDLE : T_HOLD;
          end
        end
        T_HOLD: begin
          // scanner keeps its best length until the next start
          if (slot_free) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/lcsl_store.sv
// ----------------------------------------------------------------------------
// lcsl_store: symbol memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcsl_store #(
  parameter int DEPTH = lcsl_pkg::MaxLenDefault,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lcsl_pkg::SymW-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [lcsl_pkg::SymW-1:0] rd_data
);

  logic [lcsl_pkg::SymW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/lcsl_engine.sv
// ----------------------------------------------------------------------------
// lcsl_engine: diagonal run scanner
// Walks every diagonal of the match grid, one cell per cycle, through a
// single compare / increment unit and keeps the longest run seen.
// ----------------------------------------------------------------------------
module lcsl_engine #(
  parameter int MAX_LEN = lcsl_pkg::MaxLenDefault,
  parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  parameter int CW      = $clog2(MAX_LEN + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [CW-1:0]             len_a,
  input  logic [CW-1:0]             len_b,
  output logic [AW-1:0]             addr_a,
  output logic [AW-1:0]             addr_b,
  input  logic [lcsl_pkg::SymW-1:0] data_a,
  input  logic [lcsl_pkg::SymW-1:0] data_b,
  output lcsl_pkg::eng_status_t     status
);

  typedef enum logic [1:0] {E_IDLE, E_WALK, E_DRAIN, E_DONE} state_t;

  localparam logic [CW-1:0] One = CW'(1);

  state_t        state;
  logic [CW-1:0] n, m;
  logic [CW-1:0] ia, ib;       // current cell
  logic [CW-1:0] sa, sb;       // start of current diagonal
  logic          phase_b;      // diagonals starting on the second string
  logic          at_start;
  logic          iss_v, iss_first;
  logic [CW-1:0] run, best;
  logic [CW-1:0] run_next;
  logic          end_diag;

  assign addr_a   = ia[AW-1:0];
  assign addr_b   = ib[AW-1:0];
  assign end_diag = ((ia + One) == n) || ((ib + One) == m);

  always_comb begin
    if (data_a == data_b) begin
      run_next = iss_first ? One : run + One;
    end else begin
      run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      iss_v     <= 1'b0;
      iss_first <= 1'b0;
      at_start  <= 1'b0;
      phase_b   <= 1'b0;
    end else begin
      // a cell address goes out on every walk cycle
      iss_v <= (state == E_WALK);
      unique case (state)
        E_IDLE: begin
          if (start) begin
            n        <= len_a;
            m        <= len_b;
            ia       <= '0;
            ib       <= '0;
            sa       <= '0;
            sb       <= '0;
            phase_b  <= 1'b0;
            at_start <= 1'b1;
            best     <= '0;
            state    <= (len_a == '0 || len_b == '0) ? E_DONE : E_WALK;
          end
        end
        E_WALK: begin
          iss_first <= at_start;
          if (!end_diag) begin
            ia       <= ia + One;
            ib       <= ib + One;
            at_start <= 1'b0;
          end else begin
            at_start <= 1'b1;
            if (!phase_b) begin
              if ((sa + One) < n) begin
                sa <= sa + One;
                ia <= sa + One;
                ib <= '0;
              end else if (m > One) begin
                phase_b <= 1'b1;
                sb      <= One;
                ia      <= '0;
                ib      <= One;
              end else begin
                state <= E_DRAIN;
              end
            end else begin
              if ((sb + One) < m) begin
                sb <= sb + One;
                ia <= '0;
                ib <= sb + One;
              end else begin
                state <= E_DRAIN;
              end
            end
          end
        end
        E_DRAIN: state <= E_DONE;
        E_DONE:  state <= E_IDLE;
        default: state <= E_IDLE;
      endcase

      // compare / accumulate stage, working in the cycle after the address issue
      if (iss_v) begin
        run <= run_next;
        if (run_next > best) begin
          best <= run_next;
        end
      end
    end
  end

  always_comb begin
    status.done = (state == E_DONE);
    if (32'(best) > 32'(lcsl_pkg::LenFieldMax)) begin
      status.length = lcsl_pkg::LenFieldMax;
    end else begin
      status.length = lcsl_pkg::MatchW'(best);
    end
  end

endmodule
